@@ hdl/rjtm_pkg.sv @@
// Package for the Reinhard-Jodie tone mapper: widths and luminance weights,
// imported by the divider cells, the divider and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rjtm_pkg;
    localparam int INT_BITS_DEF  = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int W_BITS        = 16;
    localparam logic [W_BITS-1:0] W_RED   = 16'd13933;
    localparam logic [W_BITS-1:0] W_GREEN = 16'd46871;
    localparam logic [W_BITS-1:0] W_BLUE  = 16'd4732;
endpackage
`default_nettype wire

@@ hdl/rjtm_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per cycle and
// passes the partial remainder to the next cell. Uses rjtm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rjtm_div_cell #(
    parameter int NW = 40,
    parameter int DW = 25
) (
    input  wire logic          i_clk,
    input  wire logic [DW:0]   i_rem,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [NW-1:0] i_quo,
    input  wire logic [DW-1:0] i_den,
    output logic [DW:0]        o_rem,
    output logic [NW-1:0]      o_num,
    output logic [NW-1:0]      o_quo,
    output logic [DW-1:0]      o_den
);
    import rjtm_pkg::*;
    logic [DW+1:0] w_sh;
    logic [DW+1:0] w_diff;
    logic          w_ge;

    always_comb begin
        w_sh   = {i_rem, i_num[NW-1]};
        w_diff = w_sh - {2'b00, i_den};
        w_ge   = (w_sh >= {2'b00, i_den});
    end

    always_ff @(posedge i_clk) begin
        o_rem <= w_ge ? w_diff[DW:0] : w_sh[DW:0];
        o_num <= {i_num[NW-2:0], 1'b0};
        o_quo <= {i_quo[NW-2:0], w_ge};
        o_den <= i_den;
    end
endmodule
`default_nettype wire

@@ hdl/rjtm_divider.sv @@
// Chain of NW restoring-division cells, each registering its step; one new
// division may enter each cycle. Uses rjtm_div_cell.
`timescale 1ns / 1ps
`default_nettype none
module rjtm_divider #(
    parameter int NW = 40,
    parameter int DW = 25
) (
    input  wire logic          i_clk,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic [NW-1:0]      o_quo
);
    import rjtm_pkg::*;
    logic [DW:0]   w_rem [NW+1];
    logic [NW-1:0] w_num [NW+1];
    logic [NW-1:0] w_quo [NW+1];
    logic [DW-1:0] w_den [NW+1];

    assign w_rem[0] = '0;
    assign w_num[0] = i_num;
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;

    for (genvar k = 0; k < NW; k++) begin : g_cell
        rjtm_div_cell #(.NW(NW), .DW(DW)) u_cell (
            .i_clk(i_clk),
            .i_rem(w_rem[k]), .i_num(w_num[k]), .i_quo(w_quo[k]), .i_den(w_den[k]),
            .o_rem(w_rem[k+1]), .o_num(w_num[k+1]), .o_quo(w_quo[k+1]),
            .o_den(w_den[k+1])
        );
    end
    assign o_quo = w_quo[NW];
endmodule
`default_nettype wire

@@ hdl/reinhard_jodie_tone_map.sv @@
// Top level of the Reinhard-Jodie tone mapper. Depends on rjtm_pkg and
// rjtm_divider.
//
// Usage: drive i_red, i_green and i_blue (unsigned Q8.16) with start high;
// the transaction is taken at each edge where start is high. busy is always
// low, so start may stay high and a new pixel be taken in every cycle.
// Pipeline: luminance product and sum registers, then a chain of INT+2*FRAC
// division cells (40 by default), then the blend multiply and output
// registers. Throughput is one pixel per cycle, set by the division cell
// chain which takes a new operand each cycle.
// The result shows on o_mapped_* for one cycle with o_valid high; the
// receiver cannot stall, so nothing is ever held back.
// Reset clears only the valid pipeline; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module reinhard_jodie_tone_map #(
    parameter int INT_BITS  = rjtm_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS = rjtm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [INT_BITS+FRAC_BITS-1:0] i_red,
    input  wire logic [INT_BITS+FRAC_BITS-1:0] i_green,
    input  wire logic [INT_BITS+FRAC_BITS-1:0] i_blue,
    output logic                               o_valid,
    output logic [FRAC_BITS:0]                 o_mapped_red,
    output logic [FRAC_BITS:0]                 o_mapped_green,
    output logic [FRAC_BITS:0]                 o_mapped_blue
);
    import rjtm_pkg::*;
    localparam int CW  = INT_BITS + FRAC_BITS;
    localparam int DW  = CW + 1;
    localparam int NW  = CW + FRAC_BITS;
    localparam int PW  = CW + W_BITS;
    localparam int LAT = NW + 4;
    localparam int AW  = 2 * FRAC_BITS + INT_BITS + 2;
    localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] OUT_MAX = '1;

    logic [CW-1:0] r_ch [3];
    logic [PW-1:0] r_prod [3];
    logic [CW-1:0] r_ch2 [3];
    logic [CW-1:0] r_lum;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;
    logic [PW+1:0] w_sum;
    logic [NW-1:0] w_tv [3];
    logic [NW-1:0] w_t  [3];
    logic [AW-1:0] r_acc [3];
    logic [FRAC_BITS:0] r_out [3];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        r_ch[0]   <= i_red;
        r_ch[1]   <= i_green;
        r_ch[2]   <= i_blue;
        r_prod[0] <= PW'(i_red) * PW'(W_RED);
        r_prod[1] <= PW'(i_green) * PW'(W_GREEN);
        r_prod[2] <= PW'(i_blue) * PW'(W_BLUE);
    end

    always_comb begin
        w_sum = (PW+2)'(r_prod[0]) + (PW+2)'(r_prod[1]) + (PW+2)'(r_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        r_lum <= w_sum[W_BITS +: CW];
        for (int k = 0; k < 3; k++) r_ch2[k] <= r_ch[k];
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
        logic [FRAC_BITS:0]   w_tvq;
        logic [CW-1:0]        w_tq;
        logic [FRAC_BITS:0]   w_inv;
        logic [AW-1:0]        w_res;

        rjtm_divider #(.NW(NW), .DW(DW)) u_div_tv (
            .i_clk(i_clk), .i_num({r_ch2[c], FRAC_BITS'(0)}),
            .i_den(ONE_Q + DW'(r_ch2[c])), .o_quo(w_tv[c])
        );
        rjtm_divider #(.NW(NW), .DW(DW)) u_div_t (
            .i_clk(i_clk), .i_num({r_ch2[c], FRAC_BITS'(0)}),
            .i_den(ONE_Q + DW'(r_lum)), .o_quo(w_t[c])
        );

        // tv < 1 always; t fits the channel width since l >= weight * c.
        assign w_tvq = w_tv[c][FRAC_BITS:0];
        assign w_tq  = w_t[c][CW-1:0];
        assign w_inv = (FRAC_BITS+1)'(ONE_Q) - w_tvq;

        always_ff @(posedge i_clk) begin
            r_acc[c] <= AW'(w_tq) * AW'(w_inv) + AW'(w_tvq) * AW'(w_tvq);
        end

        assign w_res = r_acc[c] >> FRAC_BITS;
        always_ff @(posedge i_clk) begin
            r_out[c] <= (w_res > AW'(OUT_MAX)) ? OUT_MAX : w_res[FRAC_BITS:0];
        end
    end

    assign n_vld = {r_vld[LAT-2:0], start};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid        = r_vld[LAT-1];
    assign o_mapped_red   = r_out[0];
    assign o_mapped_green = r_out[1];
    assign o_mapped_blue  = r_out[2];

    a_valid_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT (o_valid || !i_rst_n))
        else $error("result strobe missing after start");
    a_zero_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_red == '0) |-> ##LAT (o_mapped_red == '0))
        else $error("zero red did not map to zero");
endmodule
`default_nettype wire
